### hdl/sae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

  localparam int Q_W    = 16;
  localparam int DVD_W  = 26;
  localparam int DVS_W  = 16;
  localparam int DCNT_W = 5;
  localparam int MUL_W  = 27;
  localparam int MPL_W  = 10;
  localparam int MCNT_W = 4;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/sae_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sae_div
  import sae_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  dvd_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  rem_nxt;
  logic              neg_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    trial_sub;
  logic              trial_ge;
  logic [Q_W-1:0]    quot_sat;

  // one restoring step a cycle while busy: quotient bits enter the dividend register
  always_comb begin
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    trial_ge  = (trial >= {1'b0, dvs_r});
    rem_nxt   = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    dvd_nxt   = {dvd_r[DVD_W-2:0], trial_ge};
  end

  // saturate the signed quotient to Q8.8
  always_comb begin
    if (neg_r) begin
      if (dvd_r > DVD_W'(32768)) begin
        quot_sat = 16'h8000;
      end else begin
        quot_sat = Q_W'(-dvd_r[Q_W-1:0]);
      end
    end else begin
      if (dvd_r > DVD_W'(32767)) begin
        quot_sat = 16'h7FFF;
      end else begin
        quot_sat = dvd_r[Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      neg_r <= req.neg;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_sat;

endmodule

`default_nettype wire

### hdl/speed_accel_estimator.sv
// Speed and acceleration estimator, signed Q8.8. Each input item is either a
// measurement (tuser 0) or a direct load of speed and acceleration (tuser 1),
// and each gives one result item with the speed and acceleration held after
// it. Loads and the first measurement after reset pass from accept through
// ST_OUT to the registered result. A later measurement runs a bit-serial
// multiply and a one-bit-per-cycle divide for the speed average, which ends
// there when elapsed_ms is zero; with elapsed_ms positive two more
// multiply/divide passes follow for the derivative and its average. All
// passes share one restoring divider. A new item is taken while
// the previous result still waits on the output. Configuration writes are
// always taken and belong in idle time.
`timescale 1ns / 1ps
`default_nettype none

module speed_accel_estimator
  import sae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // speed_in[15:0], accel_in[31:16], elapsed_ms[47:32]
  input  wire logic        in_tuser,   // cmd[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // speed_out[15:0], accel_out[31:16]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DGO   = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] PH_AVG = 2'd0;
  localparam logic [1:0] PH_DER = 2'd1;
  localparam logic [1:0] PH_ACC = 2'd2;

  localparam logic [2:0] REG_SPEED_MAX = 3'd0;
  localparam logic [2:0] REG_SPEED_MIN = 3'd1;
  localparam logic [2:0] REG_ACCEL_MAX = 3'd2;
  localparam logic [2:0] REG_DECEL_MAX = 3'd3;
  localparam logic [2:0] REG_SPEED_WGT = 3'd4;
  localparam logic [2:0] REG_ACCEL_WGT = 3'd5;

  localparam logic       CMD_LOAD  = 1'b1;
  localparam logic [MPL_W-1:0] MS_PER_S = MPL_W'(1000);

  logic signed [15:0] speed_max_r;
  logic signed [15:0] speed_min_r;
  logic [14:0]        accel_max_r;
  logic [14:0]        decel_max_r;
  logic [7:0]         speed_wgt_r;
  logic [7:0]         accel_wgt_r;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic               first_r, first_nxt;
  logic signed [15:0] speed_est_r, speed_est_nxt;
  logic signed [15:0] accel_est_r, accel_est_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_speed_r, out_speed_nxt;
  logic [15:0]        out_accel_r, out_accel_nxt;
  logic signed [15:0] avg_r, avg_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic [MUL_W-1:0]   mcand_r, mcand_nxt;
  logic [MPL_W-1:0]   mplier_r, mplier_nxt;
  logic [MUL_W-1:0]   acc_r, acc_nxt;
  logic [MCNT_W-1:0]  mcnt_r, mcnt_nxt;

  logic signed [15:0] in_speed;
  logic signed [15:0] in_accel;
  logic signed [15:0] accel_lo;
  logic signed [15:0] accel_hi;
  logic signed [15:0] quot;
  logic signed [16:0] speed_diff;
  logic [MUL_W-1:0]   acc_mag;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    logic signed [15:0] t;
    t = (v < hi) ? v : hi;
    return (t > lo) ? t : lo;
  endfunction

  assign in_speed = in_tdata[15:0];
  assign in_accel = in_tdata[31:16];
  assign accel_hi = {1'b0, accel_max_r};
  assign accel_lo = -$signed({1'b0, decel_max_r});
  assign quot     = div_rsp.quot;
  assign acc_mag  = acc_r[MUL_W-1] ? -acc_r : acc_r;
  assign speed_diff = {quot[15], quot} - {speed_est_r[15], speed_est_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_accel_r, out_speed_r};
  assign cfg_ready  = 1'b1;

  always_comb begin
    div_req.start    = (state_r == ST_DGO);
    div_req.neg      = acc_r[MUL_W-1];
    div_req.dividend = acc_mag[DVD_W-1:0];
    case (ph_r)
      PH_AVG:  div_req.divisor = DVS_W'(speed_wgt_r) + DVS_W'(1);
      PH_DER:  div_req.divisor = dt_r;
      default: div_req.divisor = DVS_W'(accel_wgt_r) + DVS_W'(1);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    first_nxt     = first_r;
    speed_est_nxt = speed_est_r;
    accel_est_nxt = accel_est_r;
    out_valid_nxt = out_valid_r;
    out_speed_nxt = out_speed_r;
    out_accel_nxt = out_accel_r;
    avg_nxt       = avg_r;
    dt_nxt        = dt_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    mcnt_nxt      = mcnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dt_nxt = in_tdata[47:32];
          if (in_tuser == CMD_LOAD) begin
            speed_est_nxt = in_speed;
            accel_est_nxt = in_accel;
            state_nxt     = ST_OUT;
          end else if (first_r) begin
            speed_est_nxt = clamp_q(in_speed, speed_min_r, speed_max_r);
            accel_est_nxt = '0;
            first_nxt     = 1'b0;
            state_nxt     = ST_OUT;
          end else begin
            ph_nxt     = PH_AVG;
            mcand_nxt  = MUL_W'(speed_est_r);
            mplier_nxt = MPL_W'(speed_wgt_r);
            acc_nxt    = MUL_W'(in_speed);
            mcnt_nxt   = '0;
            state_nxt  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[MUL_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MPL_W-1:1]};
        mcnt_nxt   = mcnt_r + MCNT_W'(1);
        if (mcnt_r == MCNT_W'(MPL_W - 1)) begin
          state_nxt = ST_DGO;
        end
      end
      ST_DGO: begin
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          case (ph_r)
            PH_AVG: begin
              avg_nxt = quot;
              if (dt_r == '0) begin
                speed_est_nxt = clamp_q(quot, speed_min_r, speed_max_r);
                state_nxt     = ST_OUT;
              end else begin
                ph_nxt     = PH_DER;
                mcand_nxt  = MUL_W'(speed_diff);
                mplier_nxt = MS_PER_S;
                acc_nxt    = '0;
                mcnt_nxt   = '0;
                state_nxt  = ST_MUL;
              end
            end
            PH_DER: begin
              ph_nxt     = PH_ACC;
              mcand_nxt  = MUL_W'(accel_est_r);
              mplier_nxt = MPL_W'(accel_wgt_r);
              acc_nxt    = MUL_W'(quot);
              mcnt_nxt   = '0;
              state_nxt  = ST_MUL;
            end
            default: begin
              accel_est_nxt = clamp_q(quot, accel_lo, accel_hi);
              speed_est_nxt = clamp_q(avg_r, speed_min_r, speed_max_r);
              state_nxt     = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = speed_est_r;
          out_accel_nxt = accel_est_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_AVG;
      first_r     <= 1'b1;
      speed_est_r <= '0;
      accel_est_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      first_r     <= first_nxt;
      speed_est_r <= speed_est_nxt;
      accel_est_r <= accel_est_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_speed_r <= out_speed_nxt;
    out_accel_r <= out_accel_nxt;
    avg_r       <= avg_nxt;
    dt_r        <= dt_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    mcnt_r      <= mcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_max_r <= 16'sd5120;
      speed_min_r <= '0;
      accel_max_r <= 15'd512;
      decel_max_r <= 15'd256;
      speed_wgt_r <= '0;
      accel_wgt_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPEED_MAX: speed_max_r <= cfg_data;
        REG_SPEED_MIN: speed_min_r <= cfg_data;
        REG_ACCEL_MAX: accel_max_r <= cfg_data[14:0];
        REG_DECEL_MAX: decel_max_r <= cfg_data[14:0];
        REG_SPEED_WGT: speed_wgt_r <= cfg_data[7:0];
        REG_ACCEL_WGT: accel_wgt_r <= cfg_data[7:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  sae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

`default_nettype wire
